// ===== hw/rtl/cpd_pkg.sv =====
// Shared constants, the arctangent table and helpers for the cylindrical point delta block.
`timescale 1ns / 1ps
package cpd_pkg;

   localparam int CORDIC_STEPS_DEF  = 16;
   localparam int COORD_BITS_DEF    = 24;
   localparam int FRACTION_BITS_DEF = 16;

   localparam int GUARD_BITS = 4;
   localparam int TABLE_LEN  = 24;

   localparam int RADIUS_BITS = 25;
   localparam int ANGLE_BITS  = 19;
   localparam int HEIGHT_BITS = 25;

   localparam logic [63:0] INV_GAIN_Q32 = 64'd2608131496;
   localparam logic [63:0] PI_Q32       = 64'd13493037705;
   localparam logic [63:0] HALF_PI_Q32  = 64'd6746518852;

   localparam logic signed [RADIUS_BITS-1:0] WIDE_MAX = 25'sd16777215;
   localparam logic signed [RADIUS_BITS-1:0] WIDE_MIN = -25'sd16777216;

   // Entry i holds round(atan(2^-i) * 2^32).
   function automatic logic [63:0] atan_q32(input int idx);
      logic [63:0] t;
      begin
         case (idx)
            0: t = 64'd3373259426;
            1: t = 64'd1991351318;
            2: t = 64'd1052175346;
            3: t = 64'd534100635;
            4: t = 64'd268086748;
            5: t = 64'd134174063;
            6: t = 64'd67103403;
            7: t = 64'd33553749;
            8: t = 64'd16777131;
            9: t = 64'd8388597;
            10: t = 64'd4194303;
            11: t = 64'd2097152;
            12: t = 64'd1048576;
            13: t = 64'd524288;
            14: t = 64'd262144;
            15: t = 64'd131072;
            16: t = 64'd65536;
            17: t = 64'd32768;
            18: t = 64'd16384;
            19: t = 64'd8192;
            20: t = 64'd4096;
            21: t = 64'd2048;
            22: t = 64'd1024;
            default: t = 64'd512;
         endcase
         return t;
      end
   endfunction

   // Rounds a Q32 angle to the given number of fraction bits, half up.
   function automatic logic [63:0] from_q32(input logic [63:0] t, input int frac);
      begin
         return (t + (64'd1 << (31 - frac))) >> (32 - frac);
      end
   endfunction

endpackage

// ===== hw/rtl/cpd_polar.sv =====
// CORDIC vectoring pipeline that turns one Cartesian point into radius and angle.
`timescale 1ns / 1ps
module cpd_polar #(
   parameter int CORDIC_STEPS  = cpd_pkg::CORDIC_STEPS_DEF,
   parameter int COORD_BITS    = cpd_pkg::COORD_BITS_DEF,
   parameter int FRACTION_BITS = cpd_pkg::FRACTION_BITS_DEF,
   parameter int WORK_BITS     = COORD_BITS + cpd_pkg::GUARD_BITS + 3,
   parameter int ACC_BITS      = FRACTION_BITS + cpd_pkg::GUARD_BITS + 4
) (
   input  logic                        clock,
   input  logic                        advance,
   input  logic signed [COORD_BITS-1:0] pt_x,
   input  logic signed [COORD_BITS-1:0] pt_y,
   output logic signed [WORK_BITS-1:0] rot_x,
   output logic signed [ACC_BITS-1:0]  rot_z
);
   import cpd_pkg::*;

   localparam int ANG_FRAC = FRACTION_BITS + GUARD_BITS;
   localparam int STEPS    = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
   localparam logic signed [ACC_BITS-1:0] HALF_PI_A =
      ACC_BITS'(from_q32(HALF_PI_Q32, ANG_FRAC));
   localparam logic signed [ACC_BITS-1:0] PI_A = ACC_BITS'(from_q32(PI_Q32, ANG_FRAC));

   logic signed [WORK_BITS-1:0] x_ff [STEPS+1];
   logic signed [WORK_BITS-1:0] y_ff [STEPS+1];
   logic signed [ACC_BITS-1:0]  z_ff [STEPS+1];
   logic [1:0]                  axis_ff [STEPS+1]; // bit0: on x axis, bit1: negative x

   logic signed [WORK_BITS-1:0] gx, gy;
   logic signed [WORK_BITS-1:0] x0_in, y0_in;
   logic signed [ACC_BITS-1:0]  z0_in;

   // Quadrant pre-rotation into the right half plane.
   always_comb begin
      gx = WORK_BITS'(pt_x) <<< GUARD_BITS;
      gy = WORK_BITS'(pt_y) <<< GUARD_BITS;
      x0_in = gx;
      y0_in = gy;
      z0_in = '0;
      if (gx < 0) begin
         if (gy >= 0) begin
            x0_in = gy;
            y0_in = -gx;
            z0_in = HALF_PI_A;
         end else begin
            x0_in = -gy;
            y0_in = gx;
            z0_in = -HALF_PI_A;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0]    <= x0_in;
         y_ff[0]    <= y0_in;
         z_ff[0]    <= z0_in;
         axis_ff[0] <= {pt_x < 0, pt_y == '0};
      end
   end

   // One micro-rotation per stage.
   for (genvar i = 0; i < STEPS; i++) begin : g_step
      localparam logic signed [ACC_BITS-1:0] STEP_A = ACC_BITS'(from_q32(atan_q32(i), ANG_FRAC));
      always_ff @(posedge clock) begin
         if (advance) begin
            axis_ff[i+1] <= axis_ff[i];
            if (y_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + STEP_A;
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - STEP_A;
            end
         end
      end
   end

   // Points on the x axis take an exact angle.
   always_comb begin
      rot_x = x_ff[STEPS];
      if (axis_ff[STEPS][0]) begin
         rot_z = axis_ff[STEPS][1] ? PI_A : '0;
      end else begin
         rot_z = z_ff[STEPS];
      end
   end

endmodule

// ===== hw/rtl/cylindrical_point_delta.sv =====
// Top level: two CORDIC pipelines and the difference, wrap and saturation stages.
`timescale 1ns / 1ps
// Takes a pair of points per transfer and returns target minus current in radius, angle and
// height. Fully pipelined: one transfer in every cycle while the result side does not stall.
// A transfer passes through CORDIC_STEPS + 4 register stages (CORDIC_STEPS capped at
// TABLE_LEN): the pre-rotation register, the unrolled CORDIC stages, the two gain stages
// and the output register. A stall on the result side holds the whole pipeline; no
// transfer is lost.
module cylindrical_point_delta #(
   parameter int CORDIC_STEPS  = cpd_pkg::CORDIC_STEPS_DEF,
   parameter int COORD_BITS    = cpd_pkg::COORD_BITS_DEF,
   parameter int FRACTION_BITS = cpd_pkg::FRACTION_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // cur_x, cur_y, cur_z, end_x, end_y, end_z from the lowest bit up
   input  logic [((6*COORD_BITS+7)/8)*8-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // delta_radius, delta_angle, delta_height from the lowest bit up, zero padded
   output logic [71:0]              rsp_tdata
);
   import cpd_pkg::*;

   localparam int STEPS     = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
   localparam int WORK_BITS = COORD_BITS + GUARD_BITS + 3;
   localparam int ACC_BITS  = FRACTION_BITS + GUARD_BITS + 4;
   localparam int ANG_FRAC  = FRACTION_BITS + GUARD_BITS;
   localparam int DEPTH     = STEPS + 4;
   localparam int PROD_BITS = WORK_BITS + 33;
   localparam logic signed [ACC_BITS-1:0] PI_A = ACC_BITS'(from_q32(PI_Q32, ANG_FRAC));
   localparam logic signed [ACC_BITS-1:0] PI_OUT = ACC_BITS'(from_q32(PI_Q32, FRACTION_BITS));

   logic advance;
   logic [DEPTH-1:0] valid_ff;

   logic signed [COORD_BITS-1:0] cur_x, cur_y, cur_z, end_x, end_y, end_z;
   assign cur_x = req_tdata[0*COORD_BITS +: COORD_BITS];
   assign cur_y = req_tdata[1*COORD_BITS +: COORD_BITS];
   assign cur_z = req_tdata[2*COORD_BITS +: COORD_BITS];
   assign end_x = req_tdata[3*COORD_BITS +: COORD_BITS];
   assign end_y = req_tdata[4*COORD_BITS +: COORD_BITS];
   assign end_z = req_tdata[5*COORD_BITS +: COORD_BITS];

   // The pipeline moves whenever the output register is free or being emptied.
   assign advance    = !valid_ff[DEPTH-1] || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = valid_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[DEPTH-2:0], req_tvalid};
      end
   end

   logic signed [WORK_BITS-1:0] cx, ex;
   logic signed [ACC_BITS-1:0]  cz, ez;

   cpd_polar #(.CORDIC_STEPS(CORDIC_STEPS), .COORD_BITS(COORD_BITS),
               .FRACTION_BITS(FRACTION_BITS), .WORK_BITS(WORK_BITS), .ACC_BITS(ACC_BITS))
   u_cur (.clock(clock), .advance(advance), .pt_x(cur_x), .pt_y(cur_y),
          .rot_x(cx), .rot_z(cz));

   cpd_polar #(.CORDIC_STEPS(CORDIC_STEPS), .COORD_BITS(COORD_BITS),
               .FRACTION_BITS(FRACTION_BITS), .WORK_BITS(WORK_BITS), .ACC_BITS(ACC_BITS))
   u_end (.clock(clock), .advance(advance), .pt_x(end_x), .pt_y(end_y),
          .rot_x(ex), .rot_z(ez));

   // Height difference travels down a delay line beside the CORDIC.
   logic signed [COORD_BITS:0] dh_ff [DEPTH-1];
   always_ff @(posedge clock) begin
      if (advance) begin
         dh_ff[0] <= (COORD_BITS+1)'(end_z) - (COORD_BITS+1)'(cur_z);
         for (int k = 1; k < DEPTH-1; k++) begin
            dh_ff[k] <= dh_ff[k-1];
         end
      end
   end

   // Gain stage one: two partial products per radius, and the angle difference.
   logic [WORK_BITS-1:0] cu, eu;
   assign cu = (cx < 0) ? '0 : cx;
   assign eu = (ex < 0) ? '0 : ex;
   logic [PROD_BITS-1:0] chi_ff, clo_ff, ehi_ff, elo_ff;
   logic signed [ACC_BITS-1:0] za_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         chi_ff <= PROD_BITS'(cu >> 16) * PROD_BITS'(INV_GAIN_Q32);
         clo_ff <= (PROD_BITS'(cu[15:0]) * PROD_BITS'(INV_GAIN_Q32)) >> 16;
         ehi_ff <= PROD_BITS'(eu >> 16) * PROD_BITS'(INV_GAIN_Q32);
         elo_ff <= (PROD_BITS'(eu[15:0]) * PROD_BITS'(INV_GAIN_Q32)) >> 16;
         za_ff  <= ez - cz;
      end
   end

   // Gain stage two: sum, round, and wrap the angle.
   logic [PROD_BITS-1:0] csum, esum;
   assign csum = chi_ff + clo_ff + (PROD_BITS'(1) << (15 + GUARD_BITS));
   assign esum = ehi_ff + elo_ff + (PROD_BITS'(1) << (15 + GUARD_BITS));
   logic signed [ACC_BITS-1:0] za_w;
   always_comb begin
      za_w = za_ff;
      if (za_ff > PI_A) begin
         za_w = za_ff - (PI_A <<< 1);
      end else if (za_ff < -PI_A) begin
         za_w = za_ff + (PI_A <<< 1);
      end
   end
   logic signed [WORK_BITS:0] cr_ff, er_ff;
   logic signed [ACC_BITS-1:0] zw_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         cr_ff <= $signed({1'b0, WORK_BITS'(csum >> (16 + GUARD_BITS))});
         er_ff <= $signed({1'b0, WORK_BITS'(esum >> (16 + GUARD_BITS))});
         zw_ff <= za_w;
      end
   end

   // Output stage: differences, rounding and saturation.
   logic signed [WORK_BITS+1:0] dr;
   logic signed [ACC_BITS-1:0]  da;
   logic signed [RADIUS_BITS-1:0] dr_s, dh_s;
   logic signed [ANGLE_BITS-1:0]  da_s;
   always_comb begin
      dr = (WORK_BITS+2)'(er_ff) - (WORK_BITS+2)'(cr_ff);
      if (dr > (WORK_BITS+2)'(WIDE_MAX))      dr_s = WIDE_MAX;
      else if (dr < (WORK_BITS+2)'(WIDE_MIN)) dr_s = WIDE_MIN;
      else                                    dr_s = RADIUS_BITS'(dr);
      da = (zw_ff + ACC_BITS'(1 << (GUARD_BITS-1))) >>> GUARD_BITS;
      if (da > PI_OUT)       da_s = ANGLE_BITS'(PI_OUT);
      else if (da < -PI_OUT) da_s = ANGLE_BITS'(-PI_OUT);
      else                   da_s = ANGLE_BITS'(da);
      if (COORD_BITS+1 > RADIUS_BITS) begin
         if (dh_ff[DEPTH-2] > (COORD_BITS+1)'(WIDE_MAX))      dh_s = WIDE_MAX;
         else if (dh_ff[DEPTH-2] < (COORD_BITS+1)'(WIDE_MIN)) dh_s = WIDE_MIN;
         else                                                  dh_s = RADIUS_BITS'(dh_ff[DEPTH-2]);
      end else begin
         dh_s = RADIUS_BITS'(dh_ff[DEPTH-2]);
      end
   end

   logic [71:0] out_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= {3'b000, dh_s, da_s, dr_s};
      end
   end
   assign rsp_tdata = out_ff;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the cylindrical point delta block.
`timescale 1ns / 1ps

// Keeps the predicted deltas in order and compares each returned transfer against them.
class delta_scoreboard;
   typedef struct packed {
      logic signed [24:0] radius;
      logic signed [18:0] angle;
      logic signed [24:0] height;
   } delta_type;

   delta_type pending[$];
   int        errors;
   int        checked;

   // Rounds a Q32 constant to the accumulator format.
   static function longint q32_to_acc(logic [63:0] t);
      return longint'((t + (64'd1 << 11)) >> 12);
   endfunction

   // Radius (Q.20 before gain rounding) and angle in accumulator precision.
   static function void polar(longint px, longint py, output longint rad, output longint ang);
      longint x, y, z, t, dx, dy;
      logic [63:0] ux, prod;
      x = px * 16;
      y = py * 16;
      z = 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y;
            y = -t;
            z = q32_to_acc(cpd_pkg::HALF_PI_Q32);
         end else begin
            x = -y;
            y = t;
            z = -q32_to_acc(cpd_pkg::HALF_PI_Q32);
         end
      end
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx;
            y -= dy;
            z += q32_to_acc(cpd_pkg::atan_q32(i));
         end else begin
            x -= dx;
            y += dy;
            z -= q32_to_acc(cpd_pkg::atan_q32(i));
         end
      end
      if (py == 0) z = (px < 0) ? q32_to_acc(cpd_pkg::PI_Q32) : 0;
      ux = (x < 0) ? 64'd0 : 64'(x);
      prod = (ux >> 16) * cpd_pkg::INV_GAIN_Q32
           + (((ux & 64'hFFFF) * cpd_pkg::INV_GAIN_Q32) >> 16);
      rad = longint'((prod + (64'd1 << 19)) >> 20);
      ang = z;
   endfunction

   static function longint sat(longint v, longint lo, longint hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
   endfunction

   // Notes an accepted point pair and works out its expected deltas.
   function void note_points(logic [143:0] d);
      longint r0, a0, r1, a1, da, pi_acc, pi_out;
      delta_type e;
      pi_acc = q32_to_acc(cpd_pkg::PI_Q32);
      pi_out = longint'((cpd_pkg::PI_Q32 + (64'd1 << 15)) >> 16);
      polar(longint'($signed(d[23:0])), longint'($signed(d[47:24])), r0, a0);
      polar(longint'($signed(d[95:72])), longint'($signed(d[119:96])), r1, a1);
      da = a1 - a0;
      if (da > pi_acc) da -= 2 * pi_acc;
      if (da < -pi_acc) da += 2 * pi_acc;
      da = (da + 8) >>> 4;
      e.radius = 25'(sat(r1 - r0, -16777216, 16777215));
      e.angle  = 19'(sat(da, -pi_out, pi_out));
      e.height = 25'(sat(longint'($signed(d[143:120])) - longint'($signed(d[71:48])),
                         -16777216, 16777215));
      pending.push_back(e);
   endfunction

   // Compares one returned transfer with the oldest prediction.
   function void check_result(logic [71:0] d);
      delta_type e;
      checked++;
      if (pending.size() == 0) begin
         $error("unexpected result transfer %h", d);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (d[24:0] !== e.radius) begin
         $error("delta_radius expected %0d actual %0d", e.radius, $signed(d[24:0]));
         errors++;
      end
      if (d[43:25] !== e.angle) begin
         $error("delta_angle expected %0d actual %0d", e.angle, $signed(d[43:25]));
         errors++;
      end
      if (d[68:44] !== e.height) begin
         $error("delta_height expected %0d actual %0d", e.height, $signed(d[68:44]));
         errors++;
      end
   endfunction
endclass

module tb_top;
   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [143:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [71:0]  rsp_tdata;

   delta_scoreboard board = new();
   bit              calm = 1'b0;
   int              sent = 0;

   cylindrical_point_delta DUT (.*);

   always #10 clock = ~clock;

   // Records accepted transfers on both channels.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) board.note_points(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
   end

   // Receiver: stalls in random bursts until the final stretch.
   initial begin
      @(posedge clock iff !reset);
      forever begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   function automatic logic [23:0] pick_coord();
      case ($urandom_range(0, 7))
         0: return 24'h800000;
         1: return 24'h7FFFFF;
         2: return 24'h0;
         3: return 24'(int'($urandom_range(0, 64)) - 32);
         default: return 24'($urandom);
      endcase
   endfunction

   // Offers one point pair and holds it until it is taken.
   task automatic send_points(logic [23:0] cx, cy, cz, ex, ey, ez);
      req_tvalid <= 1'b1;
      req_tdata  <= {ez, ey, ex, cz, cy, cx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   task automatic pause_sender();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [23:0] c[6];
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: axes, half planes, origin, extremes and saturation.
      send_points(0, 0, 0, 0, 0, 0);
      send_points(24'h10000, 0, 0, 24'hFF0000, 0, 0);
      send_points(24'hFF0000, 0, 0, 24'h10000, 0, 0);
      send_points(24'hFF0000, 24'h1, 0, 24'hFF0000, 24'hFFFFFF, 0);
      send_points(24'hFF0000, 24'hFFFFFF, 0, 24'hFF0000, 24'h1, 0);
      send_points(0, 24'h10000, 0, 0, 24'hFF0000, 0);
      send_points(24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
      send_points(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000);
      send_points(24'h800000, 24'h7FFFFF, 0, 0, 0, 0);
      send_points(0, 0, 0, 24'h800000, 24'h800000, 24'h7FFFFF);
      send_points(24'h800000, 0, 0, 24'h7FFFFF, 0, 0);
      send_points(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h1, 24'h1, 24'h1);
      send_points(24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA);
      send_points(24'h10000, 24'h10000, 0, 24'hFFFF00, 24'h00FFFF, 0);

      // Hold the sender until the pipeline has drained once.
      pause_sender();
      while (board.pending.size() != 0) @(posedge clock);

      // Random traffic with sender gaps; the last stretch runs without idling.
      for (int n = 0; n < 850; n++) begin
         if (n == 720) calm = 1'b1;
         if (!calm && $urandom_range(0, 4) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         foreach (c[k]) c[k] = pick_coord();
         send_points(c[0], c[1], c[2], c[3], c[4], c[5]);
      end
      req_tvalid <= 1'b0;
      calm = 1'b1;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Sent %0d point pairs (axes, half planes, extremes, random) and checked %0d results.",
               sent, board.checked);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #5ms;
      $display("Regression FAIL");
      $finish;
   end
endmodule

// ===== files.f =====
hw/rtl/cpd_pkg.sv
hw/rtl/cpd_polar.sv
hw/rtl/cylindrical_point_delta.sv
bench/tb_top.sv
